// ===== sv/udwc_pkg.sv =====
// Shared types, constants and helpers for the US daylight-saving window check.
package udwc_pkg;

   localparam int unsigned NowWidth     = 32;
   localparam int unsigned MomentWidth  = 33;
   localparam int unsigned DayWidth     = 17;
   localparam int unsigned QuotWidth    = 16;
   localparam int unsigned YearOffWidth = 8;
   localparam int unsigned TodWidth     = 18;
   localparam int unsigned RuleWidth    = 2;
   localparam int unsigned OffsetWidth  = 7;
   localparam int unsigned CsrIdxWidth  = 1;
   localparam int unsigned CsrDataWidth = 7;

   localparam logic [DayWidth-1:0]    SecsPerDayW  = 17'd86400;
   localparam logic [NowWidth-1:0]    YearSecs     = 32'd31536000;
   localparam logic [NowWidth-1:0]    LeapYearSecs = 32'd31622400;

   localparam logic [8:0]  DaysPerYear  = 9'd365;
   localparam logic [DayWidth-1:0] MarchFirstOff = 17'd59;
   localparam logic [DayWidth-1:0] NovFirstOff   = 17'd304;
   localparam logic [DayWidth-1:0] DaysPerWeek   = 17'd7;
   // March 1 and November 1 both sit three weekdays on from January 1
   localparam logic [3:0]  MonthDowShift = 4'd3;
   localparam logic [2:0]  EpochDow      = 3'd4;
   localparam logic [YearOffWidth-1:0] YearOff2100 = 8'd130;

   localparam logic signed [TodWidth-1:0] SpringTodBase = 18'sd7200;
   localparam logic signed [TodWidth-1:0] SecsPerQuarter = 18'sd900;
   localparam logic signed [TodWidth-1:0] SecsPerHour    = 18'sd3600;

   localparam logic [RuleWidth-1:0] RuleUs = 2'd1;

   localparam logic [CsrIdxWidth-1:0] CsrRuleSelect = 1'd0;
   localparam logic [CsrIdxWidth-1:0] CsrBaseOffset = 1'd1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_YEAR,
      ST_DAYS,
      ST_SPRING,
      ST_FALL,
      ST_CMP,
      ST_RESP
   } udwc_state_type;

   typedef struct packed {
      logic load;
      logic year_step;
      logic calc_days;
      logic calc_spring;
      logic calc_fall;
      logic calc_active;
   } udwc_cmd_type;

   typedef struct packed {
      logic year_done;
   } udwc_status_type;

   // year offset from 1970; within the reachable range only 2100 breaks the rule of four
   function automatic logic leap_of(input logic [YearOffWidth-1:0] yoff);
      return (yoff[1:0] == 2'd2) && (yoff != YearOff2100);
   endfunction

endpackage

// ===== sv/udwc_ctrl.sv =====
// Sequencer for the year walk and moment calculation steps.
module udwc_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  udwc_pkg::udwc_status_type status,
   output udwc_pkg::udwc_cmd_type    cmd,
   output logic                     busy,
   output logic                     rsp_valid
);
   import udwc_pkg::*;

   udwc_state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_YEAR;
            end
         end
         ST_YEAR: begin
            if (status.year_done) begin
               state_in = ST_DAYS;
            end
         end
         ST_DAYS:   state_in = ST_SPRING;
         ST_SPRING: state_in = ST_FALL;
         ST_FALL:   state_in = ST_CMP;
         ST_CMP:    state_in = ST_RESP;
         ST_RESP:   state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd             = '0;
      cmd.load        = (state_ff == ST_IDLE) && start;
      cmd.year_step   = (state_ff == ST_YEAR) && !status.year_done;
      cmd.calc_days   = (state_ff == ST_DAYS);
      cmd.calc_spring = (state_ff == ST_SPRING);
      cmd.calc_fall   = (state_ff == ST_FALL);
      cmd.calc_active = (state_ff == ST_CMP);
      busy            = (state_ff != ST_IDLE);
      rsp_valid       = (state_ff == ST_RESP);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== sv/udwc_datapath.sv =====
// Datapath: config registers, year walk, transition moments and window compare.
module udwc_datapath (
   input  logic                                  clock,
   input  logic                                  reset,
   input  udwc_pkg::udwc_cmd_type                cmd,
   output udwc_pkg::udwc_status_type             status,
   input  logic [udwc_pkg::NowWidth-1:0]         req_now_utc,
   input  logic                                  csr_we,
   input  logic [udwc_pkg::CsrIdxWidth-1:0]      csr_index,
   input  logic [udwc_pkg::CsrDataWidth-1:0]     csr_wdata,
   output logic                                  rsp_dst_active,
   output logic                                  rsp_adjustment_hours,
   output logic [udwc_pkg::MomentWidth-1:0]      rsp_spring_moment,
   output logic [udwc_pkg::MomentWidth-1:0]      rsp_fall_moment
);
   import udwc_pkg::*;

   logic [RuleWidth-1:0]    rule_ff;
   logic [OffsetWidth-1:0]  offset_ff;

   logic [NowWidth-1:0]     now_ff, now_in;
   logic [NowWidth-1:0]     rem_ff, rem_in;
   logic [QuotWidth-1:0]    ys_ff, ys_in;
   logic [YearOffWidth-1:0] yoff_ff, yoff_in;
   logic [2:0]              dow_ff, dow_in;
   logic [DayWidth-1:0]     sday_ff, sday_in;
   logic [DayWidth-1:0]     fday_ff, fday_in;
   logic [MomentWidth-1:0]  spring_ff, spring_in;
   logic [MomentWidth-1:0]  fall_ff, fall_in;
   logic                    active_ff, active_in;

   logic                        leap;
   logic [8:0]                  year_len;
   logic [NowWidth-1:0]         year_secs;
   logic [3:0]                  dow_sum;
   logic [2:0]                  month_dow;
   logic [2:0]                  delta;
   logic [DayWidth-1:0]         march_day;
   logic signed [TodWidth-1:0]  qh_ext;
   logic signed [TodWidth-1:0]  spring_tod;
   logic signed [TodWidth-1:0]  fall_tod;
   logic [DayWidth-1:0]         mul_day;
   logic signed [TodWidth-1:0]  mul_tod;
   logic [MomentWidth:0]        mul_prod;
   logic signed [MomentWidth+1:0] moment;

   always_ff @(posedge clock) begin
      if (reset) begin
         rule_ff   <= '0;
         offset_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CsrRuleSelect: rule_ff   <= csr_wdata[RuleWidth-1:0];
            CsrBaseOffset: offset_ff <= csr_wdata[OffsetWidth-1:0];
            default: ;
         endcase
      end
   end

   // year bookkeeping
   always_comb begin
      leap      = leap_of(yoff_ff);
      year_len  = DaysPerYear + 9'(leap);
      year_secs = leap ? LeapYearSecs : YearSecs;
      status.year_done = (rem_ff < year_secs);
      dow_sum  = {1'b0, dow_ff} + MonthDowShift + 4'(leap);
      month_dow = (dow_sum >= 4'd7) ? 3'(dow_sum - 4'd7) : dow_sum[2:0];
      delta    = (month_dow == 3'd0) ? 3'd0 : 3'(4'd7 - {1'b0, month_dow});
      march_day = {1'b0, ys_ff} + MarchFirstOff + 17'(leap) + 17'(delta);
   end

   // signed time of day of each transition
   always_comb begin
      qh_ext     = 18'(signed'(offset_ff));
      spring_tod = SpringTodBase - qh_ext * SecsPerQuarter;
      fall_tod   = spring_tod - SecsPerHour;
      mul_day    = cmd.calc_fall ? fday_ff : sday_ff;
      mul_tod    = cmd.calc_fall ? fall_tod : spring_tod;
      mul_prod   = 34'(mul_day) * 34'(SecsPerDayW);
      moment     = signed'({1'b0, mul_prod}) + 35'(mul_tod);
   end

   always_comb begin
      logic [3:0] dow_adv;
      now_in    = now_ff;
      rem_in    = rem_ff;
      ys_in     = ys_ff;
      yoff_in   = yoff_ff;
      dow_in    = dow_ff;
      sday_in   = sday_ff;
      fday_in   = fday_ff;
      spring_in = spring_ff;
      fall_in   = fall_ff;
      active_in = active_ff;
      dow_adv   = {1'b0, dow_ff} + 4'd1 + 4'(leap);
      if (cmd.load) begin
         now_in  = req_now_utc;
         rem_in  = req_now_utc;
         ys_in   = '0;
         yoff_in = '0;
         dow_in  = EpochDow;
      end
      if (cmd.year_step) begin
         rem_in  = rem_ff - year_secs;
         ys_in   = ys_ff + {7'b0, year_len};
         yoff_in = yoff_ff + 8'd1;
         dow_in  = (dow_adv >= 4'd7) ? 3'(dow_adv - 4'd7) : dow_adv[2:0];
      end
      if (cmd.calc_days) begin
         sday_in = march_day + DaysPerWeek;
         fday_in = {1'b0, ys_ff} + NovFirstOff + 17'(leap) + 17'(delta);
      end
      if (cmd.calc_spring) begin
         spring_in = moment[MomentWidth-1:0];
      end
      if (cmd.calc_fall) begin
         fall_in = moment[MomentWidth-1:0];
      end
      if (cmd.calc_active) begin
         active_in = (rule_ff == RuleUs)
                     && ({1'b0, now_ff} >= spring_ff)
                     && ({1'b0, now_ff} < fall_ff);
      end
   end

   always_ff @(posedge clock) begin
      now_ff    <= now_in;
      rem_ff    <= rem_in;
      ys_ff     <= ys_in;
      yoff_ff   <= yoff_in;
      dow_ff    <= dow_in;
      sday_ff   <= sday_in;
      fday_ff   <= fday_in;
      spring_ff <= spring_in;
      fall_ff   <= fall_in;
      active_ff <= active_in;
   end

   assign rsp_dst_active       = active_ff;
   assign rsp_adjustment_hours = active_ff;
   assign rsp_spring_moment    = spring_ff;
   assign rsp_fall_moment      = fall_ff;

endmodule

// ===== sv/us_dst_window_check_core.sv =====
// US daylight-saving window check: top level joining sequencer and datapath.
// The sequencer walks the years since 1970 (0 to 136 of them), one year of seconds a cycle,
// then finds the days, the spring and fall moments and the window compare before rsp_valid.
// A new item is taken only in idle; busy stays high until the result cycle ends.
// Synchronous active-high reset returns the sequencer to idle and both registers to 0.
// Each result is shown for one cycle only and the receiver cannot stall it.
module us_dst_window_check_core (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic [udwc_pkg::NowWidth-1:0]         req_now_utc,
   output logic                                  rsp_valid,
   output logic                                  rsp_dst_active,
   output logic                                  rsp_adjustment_hours,
   output logic [udwc_pkg::MomentWidth-1:0]      rsp_spring_moment,
   output logic [udwc_pkg::MomentWidth-1:0]      rsp_fall_moment,
   input  logic                                  csr_we,
   input  logic [udwc_pkg::CsrIdxWidth-1:0]      csr_index,
   input  logic [udwc_pkg::CsrDataWidth-1:0]     csr_wdata
);
   import udwc_pkg::*;

   udwc_cmd_type    cmd;
   udwc_status_type status;

   udwc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .status    (status),
      .cmd       (cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   udwc_datapath u_datapath (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .status               (status),
      .req_now_utc          (req_now_utc),
      .csr_we               (csr_we),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata),
      .rsp_dst_active       (rsp_dst_active),
      .rsp_adjustment_hours (rsp_adjustment_hours),
      .rsp_spring_moment    (rsp_spring_moment),
      .rsp_fall_moment      (rsp_fall_moment)
   );

endmodule

// ===== sv/udwc_checker.sv =====
// Port-level checker for the window check core, bound to the top level.
module udwc_checker (
   input logic                                  clock,
   input logic                                  reset,
   input logic                                  start,
   input logic                                  busy,
   input logic [udwc_pkg::NowWidth-1:0]         req_now_utc,
   input logic                                  rsp_valid,
   input logic                                  rsp_dst_active,
   input logic                                  rsp_adjustment_hours,
   input logic [udwc_pkg::MomentWidth-1:0]      rsp_spring_moment,
   input logic [udwc_pkg::MomentWidth-1:0]      rsp_fall_moment,
   input logic                                  csr_we,
   input logic [udwc_pkg::CsrIdxWidth-1:0]      csr_index,
   input logic [udwc_pkg::CsrDataWidth-1:0]     csr_wdata
);
   import udwc_pkg::*;

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy && !rsp_valid)
      else $error("accepted item did not raise busy");

   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid && !busy)
      else $error("result strobe longer than one cycle");

   a_strobe_in_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("result without an item in flight");

   a_adjust_match: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_adjustment_hours == rsp_dst_active))
      else $error("adjustment differs from active flag");

   a_window_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_dst_active |-> (rsp_spring_moment < rsp_fall_moment))
      else $error("active with spring not before fall");

endmodule

bind us_dst_window_check_core udwc_checker u_udwc_checker (.*);

// ===== verif/udwc_tb_pkg.sv =====
// Window predictor and result ledger for the US daylight-saving check testbench.
package udwc_tb_pkg;

   localparam longint DaySecs  = 86400;
   localparam longint NowMax   = 64'sd4294967295;
   localparam longint FirstYear = 1970;

   localparam logic [1:0] RuleOff    = 2'd0;
   localparam logic [1:0] RuleSpare2 = 2'd2;
   localparam logic [1:0] RuleSpare3 = 2'd3;

   typedef struct {
      logic        active;
      logic        adjust;
      logic [32:0] spring;
      logic [32:0] fall;
   } dst_window_type;

   function automatic bit is_leap(input longint y);
      return ((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0;
   endfunction

   // 1970-01-01 was a Thursday
   function automatic longint first_sunday(input longint d);
      longint dow;
      dow = (d + 4) % 7;
      return d + ((7 - dow) % 7);
   endfunction

   function automatic longint year_start_day(input longint y);
      longint d;
      d = 0;
      for (longint k = FirstYear; k < y; k++) d += is_leap(k) ? 366 : 365;
      return d;
   endfunction

   function automatic void transitions(input longint yr, input longint qh,
                                       output longint spring, output longint fall);
      longint ys;
      longint tod;
      longint leap;
      ys     = year_start_day(yr);
      leap   = is_leap(yr) ? 1 : 0;
      tod    = 7200 - qh * 900;
      spring = (first_sunday(ys + 59 + leap) + 7) * DaySecs + tod;
      fall   = first_sunday(ys + 304 + leap) * DaySecs + tod - 3600;
   endfunction

   class dst_window_ledger;
      bit [1:0]        rule_sel;
      bit signed [6:0] offset_qh;
      dst_window_type  pending_windows[$];
      int unsigned     misses;

      function void set_reg(input logic idx, input logic [6:0] data);
         if (idx == udwc_pkg::CsrRuleSelect) begin
            rule_sel = data[1:0];
         end else if (idx == udwc_pkg::CsrBaseOffset) begin
            offset_qh = data;
         end
      endfunction

      function dst_window_type window_of(input logic [31:0] now);
         dst_window_type w;
         longint days;
         longint yr;
         longint len;
         longint sp;
         longint fa;
         days = longint'(now) / DaySecs;
         yr   = FirstYear;
         len  = 365;
         while (days >= len) begin
            days -= len;
            yr++;
            len = is_leap(yr) ? 366 : 365;
         end
         transitions(yr, longint'(offset_qh), sp, fa);
         w.active = (rule_sel == udwc_pkg::RuleUs) && longint'(now) >= sp && longint'(now) < fa;
         w.adjust = w.active;
         w.spring = 33'(sp);
         w.fall   = 33'(fa);
         return w;
      endfunction

      function void note_query(input logic [31:0] now);
         pending_windows.push_back(window_of(now));
      endfunction

      function void check_window(input dst_window_type got);
         dst_window_type want;
         if (pending_windows.size() == 0) begin
            misses++;
            if (misses <= 10)
               $display("unexpected result: dst %b adj %b spring %0d fall %0d",
                        got.active, got.adjust, got.spring, got.fall);
            return;
         end
         want = pending_windows.pop_front();
         if (got.active !== want.active || got.adjust !== want.adjust ||
             got.spring !== want.spring || got.fall !== want.fall) begin
            misses++;
            if (misses <= 10)
               $display("mismatch exp/act: dst %b/%b adj %b/%b spring %0d/%0d fall %0d/%0d",
                        want.active, got.active, want.adjust, got.adjust,
                        want.spring, got.spring, want.fall, got.fall);
         end
      endfunction

      function int unsigned pending_count();
         return pending_windows.size();
      endfunction

      function int unsigned failures();
         return misses + pending_windows.size();
      endfunction
   endclass

endpackage

// ===== verif/tb_top.sv =====
// Top-level testbench for the US daylight-saving window check core.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import udwc_tb_pkg::*;

   localparam int unsigned CycleLimit = 500000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [31:0] req_now_utc = '0;
   logic        rsp_valid;
   logic        rsp_dst_active;
   logic        rsp_adjustment_hours;
   logic [32:0] rsp_spring_moment;
   logic [32:0] rsp_fall_moment;
   logic        csr_we = 1'b0;
   logic [udwc_pkg::CsrIdxWidth-1:0]  csr_index = '0;
   logic [udwc_pkg::CsrDataWidth-1:0] csr_wdata = '0;

   int unsigned      cycles = 0;
   dst_window_ledger ledger = new();

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   us_dst_window_check_core dut (
      .clock                (clock),
      .reset                (reset),
      .start                (start),
      .busy                 (busy),
      .req_now_utc          (req_now_utc),
      .rsp_valid            (rsp_valid),
      .rsp_dst_active       (rsp_dst_active),
      .rsp_adjustment_hours (rsp_adjustment_hours),
      .rsp_spring_moment    (rsp_spring_moment),
      .rsp_fall_moment      (rsp_fall_moment),
      .csr_we               (csr_we),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata)
   );

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CycleLimit) begin
         $display("simulation failed");
         $finish;
      end
   end

   always @(posedge clock) begin : result_monitor
      dst_window_type got;
      if (!reset && rsp_valid === 1'b1) begin
         got.active = rsp_dst_active;
         got.adjust = rsp_adjustment_hours;
         got.spring = rsp_spring_moment;
         got.fall   = rsp_fall_moment;
         ledger.check_window(got);
      end
   end

   // all driving tasks start and end on a falling edge
   task automatic send_item(input logic [31:0] now);
      start       <= 1'b1;
      req_now_utc <= now;
      do @(posedge clock); while (busy !== 1'b0);
      ledger.note_query(now);
      @(negedge clock);
   endtask

   task automatic pause(input int unsigned n);
      start <= 1'b0;
      repeat (n) @(negedge clock);
   endtask

   task automatic drain();
      start <= 1'b0;
      while (ledger.pending_count() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_reg(input logic idx, input logic [6:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      ledger.set_reg(idx, data);
      @(negedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   task automatic send_edges(input longint yr);
      longint sp;
      longint fa;
      transitions(yr, longint'(ledger.offset_qh), sp, fa);
      send_item(32'(sp - 1));
      send_item(32'(sp));
      send_item(32'(fa - 1));
      send_item(32'(fa));
   endtask

   // half the picks near a transition or a year boundary, some at the range ends, the rest spread out
   function automatic logic [31:0] pick_now();
      longint yr;
      longint sp;
      longint fa;
      longint base;
      longint t;
      int unsigned mode;
      mode = $urandom_range(9);
      yr   = FirstYear + longint'($urandom_range(136));
      transitions(yr, longint'(ledger.offset_qh), sp, fa);
      base = $urandom_range(1) ? sp : fa;
      case (mode)
         0, 1, 2: t = longint'($urandom);
         3, 4:    t = base + longint'($urandom_range(6)) - 3;
         5:       t = base + ($urandom_range(1) ? 3600 : -3600) + longint'($urandom_range(2)) - 1;
         6:       t = base + (longint'($urandom_range(14)) - 7) * 900
                       + (longint'($urandom_range(2)) - 1) * DaySecs;
         7:       t = year_start_day(yr) * DaySecs + longint'($urandom_range(4)) - 2;
         8:       t = year_start_day(yr) * DaySecs + longint'($urandom_range(365 * 86400));
         default: t = $urandom_range(1) ? NowMax - longint'($urandom_range(3))
                                        : longint'($urandom_range(3));
      endcase
      if (t < 0 || t > NowMax) t = longint'($urandom);
      return t[31:0];
   endfunction

   task automatic random_phase(input logic [1:0] rule, input int offset, input int n,
                               input int unsigned idle_pct);
      drain();
      write_reg(udwc_pkg::CsrRuleSelect, 7'(rule));
      write_reg(udwc_pkg::CsrBaseOffset, 7'(offset));
      repeat (n) begin
         send_item(pick_now());
         if ($urandom_range(99) < idle_pct) pause($urandom_range(1, 18));
      end
   endtask

   initial begin
      repeat (9) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // registers still at reset: rule off
      send_item(32'h0000_0000);
      send_item(32'hFFFF_FFFF);
      send_edges(1990);

      drain();
      write_reg(udwc_pkg::CsrRuleSelect, 7'(udwc_pkg::RuleUs));
      write_reg(udwc_pkg::CsrBaseOffset, 7'(-20));
      send_item(32'h0000_0000);
      send_item(32'hFFFF_FFFF);
      send_item(32'd31535999);
      send_item(32'd31536000);
      send_edges(1970);
      send_edges(2000);
      send_edges(2100);

      // far east offset pushes both moments into the previous UTC day
      drain();
      write_reg(udwc_pkg::CsrBaseOffset, 7'(63));
      send_edges(2024);

      random_phase(udwc_pkg::RuleUs, -20, 60, 30);
      random_phase(udwc_pkg::RuleUs, -32, 50, 50);
      random_phase(udwc_pkg::RuleUs, 63, 50, 30);
      random_phase(udwc_pkg::RuleUs, -64, 50, 30);
      random_phase(RuleSpare2, -28, 30, 40);
      random_phase(RuleSpare3, 56, 30, 30);
      random_phase(RuleOff, -56, 30, 30);
      random_phase(udwc_pkg::RuleUs, 56, 50, 30);
      random_phase(udwc_pkg::RuleUs, int'($urandom_range(127)) - 64, 50, 30);
      random_phase(udwc_pkg::RuleUs, -24, 50, 0);

      drain();
      repeat (200) @(posedge clock);
      if (ledger.failures() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
